// ===== hdl/sphere_overlap_channel_assigner_macros.svh =====
// Assertion macros for the sphere overlap channel assigner.
// Depends on nothing; the top level includes it by file name.
`ifndef SPHERE_OVERLAP_CHANNEL_ASSIGNER_MACROS_SVH
`define SPHERE_OVERLAP_CHANNEL_ASSIGNER_MACROS_SVH
`ifndef SYNTHESIS
`define SOCA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("soca check failed");
`define SOCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("soca check failed");
`else
`define SOCA_ASSERT_SAME(label, ante, cons)
`define SOCA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/soca_pkg.sv =====
// Shared constants and types of the sphere overlap channel assigner.
// Used by every module of the block; depends on nothing.
package soca_pkg;
  localparam int MAX_LIGHTS = 255;
  localparam int NUM_CHANNELS = 4;
  localparam int IDX_W = 8;
  localparam int CH_W = 3;
  localparam logic [CH_W-1:0] NO_CHANNEL = 3'd4;

  localparam logic [1:0] STATUS_ASSIGNED = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0] radius;
    logic [CH_W-1:0] channel;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic valid;
    logic hit;
    logic [CH_W-1:0] channel;
  } overlap_res_t;
endpackage

// ===== hdl/soca_cell.sv =====
// One cell of the rotating light store: holds one stored sphere.
// Depends on soca_pkg.
module soca_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  logic            wr_en,
  input  soca_pkg::entry_t shift_in,
  input  soca_pkg::entry_t wr_data,
  output soca_pkg::entry_t entry
);
  soca_pkg::entry_t entry_r;
  soca_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (wr_en) begin
      entry_nxt = wr_data;
    end else if (shift_en) begin
      entry_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
endmodule

// ===== hdl/soca_overlap.sv =====
// Three stage sphere overlap test between the query and one stored sphere.
// Depends on soca_pkg.
module soca_overlap (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic signed [15:0] q_x,
  input  logic signed [15:0] q_y,
  input  logic signed [15:0] q_z,
  input  logic [15:0]      q_r,
  input  soca_pkg::entry_t  entry,
  output soca_pkg::overlap_res_t res
);
  logic signed [16:0] dx, dy, dz;
  logic [16:0] ax_nxt, ay_nxt, az_nxt, rs_nxt;
  logic [16:0] ax_r, ay_r, az_r, rs_r;
  logic [33:0] sx_r, sy_r, sz_r, rr_r;
  logic [soca_pkg::CH_W-1:0] ch1_r, ch2_r, ch3_r;
  logic v1_r, v2_r, v3_r, hit_r;
  logic [34:0] dist_sum;

  always_comb begin
    dx = 17'(q_x) - 17'(entry.pos_x);
    dy = 17'(q_y) - 17'(entry.pos_y);
    dz = 17'(q_z) - 17'(entry.pos_z);
    ax_nxt = dx[16] ? 17'(-dx) : 17'(dx);
    ay_nxt = dy[16] ? 17'(-dy) : 17'(dy);
    az_nxt = dz[16] ? 17'(-dz) : 17'(dz);
    rs_nxt = {1'b0, q_r} + {1'b0, entry.radius};
    dist_sum = {1'b0, sx_r} + {1'b0, sy_r} + {1'b0, sz_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    ax_r <= ax_nxt;
    ay_r <= ay_nxt;
    az_r <= az_nxt;
    rs_r <= rs_nxt;
    ch1_r <= entry.channel;
    sx_r <= ax_r * ax_r;
    sy_r <= ay_r * ay_r;
    sz_r <= az_r * az_r;
    rr_r <= rs_r * rs_r;
    ch2_r <= ch1_r;
    hit_r <= dist_sum <= {1'b0, rr_r};
    ch3_r <= ch2_r;
  end

  assign res.busy = v1_r | v2_r | v3_r;
  assign res.valid = v3_r;
  assign res.hit = hit_r;
  assign res.channel = ch3_r;
endmodule

// ===== hdl/sphere_overlap_channel_assigner.sv =====
// Sphere overlap channel assigner: a ring of light cells and one shared overlap unit.
// Depends on soca_pkg, soca_cell, soca_overlap and the assertion macros header.
//
// Each place word rotates the whole ring of 255 light cells once past one pipelined
// overlap unit, so its result is offered after the ring steps, the drain of the overlap
// pipeline and the load of the result register. A clear word gives no result; a place
// word into a full table skips the scan and goes straight to the result register. A new
// word is taken as soon as the previous one is finished, even while its result waits.
`include "sphere_overlap_channel_assigner_macros.svh"
module sphere_overlap_channel_assigner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic [15:0] in_radius,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_light_number,
  output logic [2:0]  out_channel,
  output logic [1:0]  out_status
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [soca_pkg::IDX_W-1:0] total_r, total_nxt;
  logic [soca_pkg::IDX_W-1:0] step_r, step_nxt;
  logic [soca_pkg::NUM_CHANNELS-1:0] mask_r, mask_nxt;
  logic full_r, full_nxt;
  logic signed [15:0] qx_r, qy_r, qz_r;
  logic [15:0] qr_r;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] num_r, num_nxt;
  logic [2:0] ch_r, ch_nxt;
  logic [1:0] st_r, st_nxt;
  logic in_acc, emit, scanning;
  logic [soca_pkg::CH_W-1:0] pick;
  soca_pkg::entry_t new_entry;
  soca_pkg::entry_t ring [soca_pkg::MAX_LIGHTS];
  soca_pkg::overlap_res_t ov;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc = in_valid & in_ready;
  assign scanning = (state_r == S_SCAN);
  assign emit = (state_r == S_DONE) & (~out_valid_r | out_ready);

  always_comb begin
    pick = soca_pkg::NO_CHANNEL;
    for (int c = soca_pkg::NUM_CHANNELS - 1; c >= 0; c--) begin
      if (!mask_r[c]) begin
        pick = soca_pkg::CH_W'(c);
      end
    end
  end

  assign new_entry = '{pos_x: qx_r, pos_y: qy_r, pos_z: qz_r, radius: qr_r, channel: pick};

  for (genvar i = 0; i < soca_pkg::MAX_LIGHTS; i++) begin : g_cell
    soca_cell u_cell (
      .clk      (clk),
      .shift_en (scanning),
      .wr_en    (emit & ~full_r & (total_r == soca_pkg::IDX_W'(i))),
      .shift_in (ring[(i + 1) % soca_pkg::MAX_LIGHTS]),
      .wr_data  (new_entry),
      .entry    (ring[i])
    );
  end

  soca_overlap u_overlap (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (scanning & (step_r < total_r)),
    .q_x    (qx_r),
    .q_y    (qy_r),
    .q_z    (qz_r),
    .q_r    (qr_r),
    .entry  (ring[0]),
    .res    (ov)
  );

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    step_nxt = step_r;
    mask_nxt = mask_r;
    full_nxt = full_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    num_nxt = num_r;
    ch_nxt = ch_r;
    st_nxt = st_r;
    if (ov.valid && ov.hit && ov.channel < soca_pkg::CH_W'(soca_pkg::NUM_CHANNELS)) begin
      mask_nxt[ov.channel[1:0]] = 1'b1;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          step_nxt = '0;
          mask_nxt = '0;
          full_nxt = (total_r >= soca_pkg::IDX_W'(soca_pkg::MAX_LIGHTS));
          if (!in_cmd) begin
            total_nxt = '0;
          end else if (total_r >= soca_pkg::IDX_W'(soca_pkg::MAX_LIGHTS)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == soca_pkg::IDX_W'(soca_pkg::MAX_LIGHTS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!ov.busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (full_r) begin
            num_nxt = '0;
            ch_nxt = soca_pkg::NO_CHANNEL;
            st_nxt = soca_pkg::STATUS_FULL;
          end else begin
            total_nxt = total_r + 1'b1;
            num_nxt = total_r + 1'b1;
            ch_nxt = pick;
            st_nxt = (pick == soca_pkg::NO_CHANNEL) ? soca_pkg::STATUS_NO_FREE
                                                   : soca_pkg::STATUS_ASSIGNED;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r <= step_nxt;
    mask_r <= mask_nxt;
    full_r <= full_nxt;
    num_r <= num_nxt;
    ch_r <= ch_nxt;
    st_r <= st_nxt;
    if (in_acc) begin
      qx_r <= in_pos_x;
      qy_r <= in_pos_y;
      qz_r <= in_pos_z;
      qr_r <= in_radius;
    end
  end

  assign out_valid = out_valid_r;
  assign out_light_number = num_r;
  assign out_channel = ch_r;
  assign out_status = st_r;

  `SOCA_ASSERT_SAME(a_state_onehot, 1'b1, $onehot(state_r))
  `SOCA_ASSERT_SAME(a_total_bound, 1'b1, total_r <= soca_pkg::IDX_W'(soca_pkg::MAX_LIGHTS))
  `SOCA_ASSERT_SAME(a_number_set, out_valid && out_status != soca_pkg::STATUS_FULL, out_light_number != 8'd0)
  `SOCA_ASSERT_NEXT(a_place_starts, in_acc && in_cmd, state_r != S_IDLE)
endmodule

// ===== tb/tb_sphere_overlap_channel_assigner.sv =====
// Testbench for the sphere overlap channel assigner: directed and random light placements.
// Depends on soca_pkg and the block; predicts each placement result from its own light table.
module tb_sphere_overlap_channel_assigner;
  typedef struct {
    logic [7:0] light_number;
    logic [2:0] channel;
    logic [1:0] status;
  } placement_t;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_PLACE = 1'b1;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = 1'b0;
  logic signed [15:0] in_pos_x = '0;
  logic signed [15:0] in_pos_y = '0;
  logic signed [15:0] in_pos_z = '0;
  logic [15:0] in_radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_light_number;
  logic [2:0] out_channel;
  logic [1:0] out_status;

  logic signed [15:0] lit_x [soca_pkg::MAX_LIGHTS];
  logic signed [15:0] lit_y [soca_pkg::MAX_LIGHTS];
  logic signed [15:0] lit_z [soca_pkg::MAX_LIGHTS];
  logic [15:0] lit_r [soca_pkg::MAX_LIGHTS];
  logic [2:0] lit_ch [soca_pkg::MAX_LIGHTS];
  int lights_stored = 0;
  placement_t pending_placements[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;

  sphere_overlap_channel_assigner dut (.*);

  always #1 clk = ~clk;

  function automatic logic overlaps(int k, logic signed [15:0] x, logic signed [15:0] y,
                                    logic signed [15:0] z, logic [15:0] r);
    longint dx, dy, dz, rs;
    dx = longint'(x) - longint'(lit_x[k]);
    dy = longint'(y) - longint'(lit_y[k]);
    dz = longint'(z) - longint'(lit_z[k]);
    rs = longint'(r) + longint'(lit_r[k]);
    return (dx * dx + dy * dy + dz * dz) <= rs * rs;
  endfunction

  task automatic predict_placement(logic cmd, logic signed [15:0] x, logic signed [15:0] y,
                                   logic signed [15:0] z, logic [15:0] r);
    placement_t p;
    logic [2:0] ch;
    logic hit;
    if (cmd == CMD_CLEAR) begin
      lights_stored = 0;
      return;
    end
    if (lights_stored >= soca_pkg::MAX_LIGHTS) begin
      p.light_number = 8'd0;
      p.channel = soca_pkg::NO_CHANNEL;
      p.status = soca_pkg::STATUS_FULL;
      pending_placements = {pending_placements, p};
      return;
    end
    ch = soca_pkg::NO_CHANNEL;
    for (int c = 0; c < soca_pkg::NUM_CHANNELS; c++) begin
      hit = 1'b0;
      for (int k = 0; k < lights_stored; k++) begin
        if (lit_ch[k] == 3'(c) && overlaps(k, x, y, z, r)) begin
          hit = 1'b1;
          break;
        end
      end
      if (!hit) begin
        ch = 3'(c);
        break;
      end
    end
    lit_x[lights_stored] = x;
    lit_y[lights_stored] = y;
    lit_z[lights_stored] = z;
    lit_r[lights_stored] = r;
    lit_ch[lights_stored] = ch;
    lights_stored++;
    p.light_number = 8'(lights_stored);
    p.channel = ch;
    p.status = (ch == soca_pkg::NO_CHANNEL) ? soca_pkg::STATUS_NO_FREE
                                            : soca_pkg::STATUS_ASSIGNED;
    pending_placements = {pending_placements, p};
  endtask

  task automatic send_word(logic cmd, logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic [15:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_radius <= r;
    do @(posedge clk); while (!in_ready);
    predict_placement(cmd, x, y, z, r);
    @(negedge clk);
  endtask

  task automatic place_random_cluster();
    logic signed [15:0] cx, cy, cz;
    int span;
    span = $urandom_range(1) ? 64 : 2048;
    cx = 16'($urandom);
    cy = 16'($urandom);
    cz = 16'($urandom);
    send_word(CMD_PLACE, cx + 16'($urandom_range(span)), cy + 16'($urandom_range(span)),
              cz + 16'($urandom_range(span)), 16'($urandom_range(span / 2)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_placements.size() != 0) @(negedge clk);
  endtask

  task automatic test_extremes();
    send_word(CMD_CLEAR, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'hffff);
    send_word(CMD_PLACE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff);
    send_word(CMD_PLACE, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff);
    send_word(CMD_PLACE, 16'sh8000, 16'sh7fff, 16'sh0000, 16'h0000);
    send_word(CMD_PLACE, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000);
    send_word(CMD_PLACE, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000);
    send_word(CMD_CLEAR, '0, '0, '0, '0);
  endtask

  task automatic test_touching_and_no_free();
    send_word(CMD_PLACE, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0010);
    send_word(CMD_PLACE, 16'sh0020, 16'sh0000, 16'sh0000, 16'h0010);
    send_word(CMD_PLACE, 16'sh0021, 16'sh0000, 16'sh0000, 16'h0010);
    for (int i = 0; i < 4; i++) send_word(CMD_PLACE, 16'sh0005, '0, '0, 16'h0100);
    send_word(CMD_PLACE, 16'sh0005, '0, '0, 16'h0001);
    send_word(CMD_CLEAR, '0, '0, '0, '0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < soca_pkg::MAX_LIGHTS + 3; i++) place_random_cluster();
    send_word(CMD_CLEAR, '0, '0, '0, '0);
  endtask

  task automatic test_random(int words);
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(99) < 3) send_word(CMD_CLEAR, 16'($urandom), 16'($urandom),
                                            16'($urandom), 16'($urandom));
      else if ($urandom_range(99) < 8)
        send_word(CMD_PLACE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else place_random_cluster();
    end
  endtask

  task automatic test_back_pressure();
    hold_off = 1500;
    for (int i = 0; i < 8; i++) place_random_cluster();
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    placement_t exp_p;
    if (rst_n && out_valid && out_ready) begin
      if (pending_placements.size() == 0) begin
        $display("%0t: unexpected word: number %0d channel %0d status %0d", $time,
                 out_light_number, out_channel, out_status);
        errors++;
      end else begin
        exp_p = pending_placements.pop_front();
        if (out_light_number !== exp_p.light_number) begin
          $display("%0t: light_number expected %0d actual %0d", $time,
                   exp_p.light_number, out_light_number);
          errors++;
        end
        if (out_channel !== exp_p.channel) begin
          $display("%0t: channel expected %0d actual %0d", $time, exp_p.channel, out_channel);
          errors++;
        end
        if (out_status !== exp_p.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_p.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sphere_overlap_channel_assigner failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_touching_and_no_free();
    send_idle_pct = 11;
    recv_idle_pct = 53;
    test_table_full();
    test_random(700);
    drain();
    test_back_pressure();
    send_idle_pct = 53;
    recv_idle_pct = 11;
    test_random(650);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(650);
    drain();
    repeat (300) @(negedge clk);
    if (errors == 0 && pending_placements.size() == 0) begin
      $display("tb_sphere_overlap_channel_assigner passed");
    end else begin
      $display("tb_sphere_overlap_channel_assigner failed");
    end
    $finish;
  end
endmodule
